/* hdl/lpff_pkg.sv */
// shared types and constants for the length-prefixed frame fifo
// used by the controller, the datapath and the top level
package lpff_pkg;

  localparam int unsigned HEADER_BYTES = 4;
  localparam int unsigned LEN_W        = 10;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned STAT_W       = 2;
  localparam int unsigned ACT_W        = 2;
  localparam int unsigned HDR_IDX_W    = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_WR_BEGIN = 2'd0,
    ACT_WR_BYTE  = 2'd1,
    ACT_RD_BEGIN = 2'd2,
    ACT_RD_BYTE  = 2'd3
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_SEQ  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    OP_IDLE     = 4'd0,
    OP_SEQ_ERR  = 4'd1,
    OP_NO_FRAME = 4'd2,
    OP_WR_FULL  = 4'd3,
    OP_WR_HDR   = 4'd4,
    OP_WR_BYTE  = 4'd5,
    OP_WR_DROP  = 4'd6,
    OP_RD_LO    = 4'd7,
    OP_RD_HDR   = 4'd8,
    OP_RD_BYTE  = 4'd9
  } dp_op_e;

  typedef struct packed {
    dp_op_e               op;
    logic [HDR_IDX_W-1:0] hdr_idx;
    logic                 hdr_last;
  } dp_cmd_t;

  typedef struct packed {
    logic write_open;
    logic dropping;
    logic read_open;
    logic frame_ready;
    logic frame_fits;
  } dp_stat_t;

endpackage

/* hdl/lpff_ram.sv */
// generic single write port ram with registered read
// no dependencies
module lpff_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/lpff_ctrl.sv */
// sequencing state machine of the frame fifo
// depends on lpff_pkg, drives the datapath command
module lpff_ctrl import lpff_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  logic [ACT_W-1:0]     action_i,
  input  dp_stat_t             stat_i,
  output dp_cmd_t              cmd_o,
  output logic                 busy
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WHDR  = 5'b00010,
    S_RLO   = 5'b00100,
    S_RHDR  = 5'b01000,
    S_RBYTE = 5'b10000
  } state_e;

  localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HEADER_BYTES - 1);

  state_e               state_q, state_d;
  logic [HDR_IDX_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmd_o.op     = OP_IDLE;
    cmd_o.hdr_idx = cnt_q;
    cmd_o.hdr_last = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          unique case (action_e'(action_i))
            ACT_WR_BEGIN: begin
              if (stat_i.write_open) begin
                cmd_o.op = OP_SEQ_ERR;
              end else if (!stat_i.frame_fits) begin
                cmd_o.op = OP_WR_FULL;
              end else begin
                cmd_o.op      = OP_WR_HDR;
                cmd_o.hdr_idx = '0;
                cnt_d         = HDR_IDX_W'(1);
                state_d       = S_WHDR;
              end
            end
            ACT_WR_BYTE: begin
              if (!stat_i.write_open) begin
                cmd_o.op = OP_SEQ_ERR;
              end else if (stat_i.dropping) begin
                cmd_o.op = OP_WR_DROP;
              end else begin
                cmd_o.op = OP_WR_BYTE;
              end
            end
            ACT_RD_BEGIN: begin
              if (stat_i.read_open) begin
                cmd_o.op = OP_SEQ_ERR;
              end else if (!stat_i.frame_ready) begin
                cmd_o.op = OP_NO_FRAME;
              end else begin
                state_d = S_RLO;
              end
            end
            ACT_RD_BYTE: begin
              if (!stat_i.read_open) begin
                cmd_o.op = OP_SEQ_ERR;
              end else begin
                state_d = S_RBYTE;
              end
            end
            default: cmd_o.op = OP_IDLE;
          endcase
        end
      end
      S_WHDR: begin
        cmd_o.op       = OP_WR_HDR;
        cmd_o.hdr_last = (cnt_q == HDR_LAST);
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == HDR_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_RLO: begin
        cmd_o.op = OP_RD_LO;
        state_d  = S_RHDR;
      end
      S_RHDR: begin
        cmd_o.op = OP_RD_HDR;
        state_d  = S_IDLE;
      end
      S_RBYTE: begin
        cmd_o.op = OP_RD_BYTE;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

/* hdl/lpff_datapath.sv */
// ring indices, counters, byte ram and result registers of the frame fifo
// depends on lpff_pkg and lpff_ram
module lpff_datapath import lpff_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  input  logic [LEN_W-1:0]  frame_length_i,
  input  logic [BYTE_W-1:0] write_byte_i,
  output dp_stat_t          stat_o,
  output logic              result_valid_o,
  output logic [STAT_W-1:0] status_o,
  output logic [LEN_W-1:0]  length_out_o,
  output logic [BYTE_W-1:0] read_byte_o,
  output logic              last_o
);

  localparam int unsigned IW = $clog2(BUFFER_BYTES);
  localparam int unsigned UW = IW + 1;
  localparam int unsigned CW = (UW > LEN_W + 1) ? UW : LEN_W + 1;
  localparam logic [IW-1:0] IDX_MAX = IW'(BUFFER_BYTES - 1);

  logic [IW-1:0]     rd_idx_q, rd_idx_d;
  logic [IW-1:0]     cwr_idx_q, cwr_idx_d;
  logic [IW-1:0]     pwr_idx_q, pwr_idx_d;
  logic [UW-1:0]     used_q, used_d;
  logic [LEN_W-1:0]  wr_rem_q, wr_rem_d;
  logic [LEN_W-1:0]  rd_rem_q, rd_rem_d;
  logic              dropping_q, dropping_d;
  logic [LEN_W-1:0]  open_len_q, open_len_d;
  logic [BYTE_W-1:0] lo_q, lo_d;

  logic              res_valid_q, res_valid_d;
  status_e           res_status_q, res_status_d;
  logic [LEN_W-1:0]  res_len_q, res_len_d;
  logic [BYTE_W-1:0] res_byte_q, res_byte_d;
  logic              res_last_q, res_last_d;

  logic              ram_we;
  logic [BYTE_W-1:0] ram_wdata;
  logic [IW-1:0]     ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic [BYTE_W-1:0] hdr_byte;
  logic [UW-1:0]     commit_used;
  logic [IW-1:0]     pwr_inc;
  logic [LEN_W-1:0]  rd_len;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx);
    return (idx == IDX_MAX) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_add_hdr(input logic [IW-1:0] idx);
    logic [IW:0] s;
    s = {1'b0, idx} + (IW+1)'(HEADER_BYTES);
    if (s >= (IW+1)'(BUFFER_BYTES)) begin
      s = s - (IW+1)'(BUFFER_BYTES);
    end
    return s[IW-1:0];
  endfunction

  lpff_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pwr_idx_q),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_raddr   = (cmd_i.op == OP_RD_LO) ? idx_inc(rd_idx_q) : rd_idx_q;
  assign pwr_inc     = idx_inc(pwr_idx_q);
  assign commit_used = UW'(CW'(used_q) + CW'(HEADER_BYTES) + CW'(open_len_q));
  assign rd_len      = LEN_W'({ram_rdata, lo_q});

  always_comb begin
    case (cmd_i.hdr_idx)
      HDR_IDX_W'(0): hdr_byte = frame_length_i[BYTE_W-1:0];
      HDR_IDX_W'(1): hdr_byte = BYTE_W'(open_len_q >> BYTE_W);
      default:       hdr_byte = '0;
    endcase
  end

  assign stat_o.write_open  = (wr_rem_q != '0);
  assign stat_o.dropping    = dropping_q;
  assign stat_o.read_open   = (rd_rem_q != '0);
  assign stat_o.frame_ready = (used_q >= UW'(HEADER_BYTES));
  assign stat_o.frame_fits  = (CW'(HEADER_BYTES) + CW'(frame_length_i))
                              <= (CW'(BUFFER_BYTES) - CW'(used_q));

  always_comb begin
    rd_idx_d     = rd_idx_q;
    cwr_idx_d    = cwr_idx_q;
    pwr_idx_d    = pwr_idx_q;
    used_d       = used_q;
    wr_rem_d     = wr_rem_q;
    rd_rem_d     = rd_rem_q;
    dropping_d   = dropping_q;
    open_len_d   = open_len_q;
    lo_d         = lo_q;
    res_valid_d  = 1'b0;
    res_status_d = ST_OK;
    res_len_d    = '0;
    res_byte_d   = '0;
    res_last_d   = 1'b0;
    ram_we       = 1'b0;
    ram_wdata    = write_byte_i;
    unique case (cmd_i.op)
      OP_IDLE: begin
        res_valid_d = 1'b0;
      end
      OP_SEQ_ERR: begin
        res_valid_d  = 1'b1;
        res_status_d = ST_SEQ;
      end
      OP_NO_FRAME: begin
        res_valid_d  = 1'b1;
        res_status_d = ST_FULL;
      end
      OP_WR_FULL: begin
        res_valid_d  = 1'b1;
        res_status_d = ST_FULL;
        if (frame_length_i == '0) begin
          res_last_d = 1'b1;
        end else begin
          wr_rem_d   = frame_length_i;
          dropping_d = 1'b1;
        end
      end
      OP_WR_HDR: begin
        ram_we    = 1'b1;
        ram_wdata = hdr_byte;
        pwr_idx_d = pwr_inc;
        if (cmd_i.hdr_idx == '0) begin
          open_len_d = frame_length_i;
          wr_rem_d   = frame_length_i;
          dropping_d = 1'b0;
        end
        if (cmd_i.hdr_last) begin
          res_valid_d = 1'b1;
          if (open_len_q == '0) begin
            cwr_idx_d  = pwr_inc;
            used_d     = commit_used;
            res_last_d = 1'b1;
          end
        end
      end
      OP_WR_BYTE: begin
        ram_we      = 1'b1;
        pwr_idx_d   = pwr_inc;
        wr_rem_d    = wr_rem_q - 1'b1;
        res_valid_d = 1'b1;
        if (wr_rem_q == LEN_W'(1)) begin
          cwr_idx_d  = pwr_inc;
          used_d     = commit_used;
          res_last_d = 1'b1;
        end
      end
      OP_WR_DROP: begin
        res_valid_d  = 1'b1;
        res_status_d = ST_FULL;
        wr_rem_d     = wr_rem_q - 1'b1;
        if (wr_rem_q == LEN_W'(1)) begin
          dropping_d = 1'b0;
          res_last_d = 1'b1;
        end
      end
      OP_RD_LO: begin
        lo_d = ram_rdata;
      end
      OP_RD_HDR: begin
        rd_idx_d    = idx_add_hdr(rd_idx_q);
        used_d      = used_q - UW'(HEADER_BYTES);
        rd_rem_d    = rd_len;
        res_valid_d = 1'b1;
        res_len_d   = rd_len;
        if (rd_len == '0) begin
          res_last_d = 1'b1;
          if (used_d == '0 && pwr_idx_q == cwr_idx_q) begin
            rd_idx_d  = '0;
            cwr_idx_d = '0;
            pwr_idx_d = '0;
          end
        end
      end
      OP_RD_BYTE: begin
        rd_idx_d    = idx_inc(rd_idx_q);
        used_d      = used_q - 1'b1;
        rd_rem_d    = rd_rem_q - 1'b1;
        res_valid_d = 1'b1;
        res_byte_d  = ram_rdata;
        if (rd_rem_q == LEN_W'(1)) begin
          res_last_d = 1'b1;
          if (used_d == '0 && pwr_idx_q == cwr_idx_q) begin
            rd_idx_d  = '0;
            cwr_idx_d = '0;
            pwr_idx_d = '0;
          end
        end
      end
      default: begin
        res_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q    <= '0;
      cwr_idx_q   <= '0;
      pwr_idx_q   <= '0;
      used_q      <= '0;
      wr_rem_q    <= '0;
      rd_rem_q    <= '0;
      dropping_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      rd_idx_q    <= rd_idx_d;
      cwr_idx_q   <= cwr_idx_d;
      pwr_idx_q   <= pwr_idx_d;
      used_q      <= used_d;
      wr_rem_q    <= wr_rem_d;
      rd_rem_q    <= rd_rem_d;
      dropping_q  <= dropping_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    open_len_q   <= open_len_d;
    lo_q         <= lo_d;
    res_status_q <= res_status_d;
    res_len_q    <= res_len_d;
    res_byte_q   <= res_byte_d;
    res_last_q   <= res_last_d;
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = res_status_q;
  assign length_out_o   = res_len_q;
  assign read_byte_o    = res_byte_q;
  assign last_o         = res_last_q;

endmodule

/* hdl/length_prefixed_frame_fifo.sv */
// top level of the length-prefixed frame fifo
// depends on lpff_pkg, lpff_ctrl and lpff_datapath
//
// A word is taken when start is high and busy is low; every word gives exactly one
// result, shown for one cycle with result_valid_o high, and the receiver cannot stall
// it. A write payload byte, a dropped byte and any rejected word are handled in the
// idle state, so payload writes stream at one word per cycle. An admitted begin write
// writes its header bytes one after another; a begin read visits the low byte and
// header states and a read payload byte the byte state, both set by the single
// registered read port of the byte ram. The result appears in the cycle after
// the last step; a new word may start then. There is no clearing pass after reset.
module length_prefixed_frame_fifo import lpff_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [ACT_W-1:0]  action_i,
  input  logic [LEN_W-1:0]  frame_length_i,
  input  logic [BYTE_W-1:0] write_byte_i,
  output logic              result_valid_o,
  output logic [STAT_W-1:0] status_o,
  output logic [LEN_W-1:0]  length_out_o,
  output logic [BYTE_W-1:0] read_byte_o,
  output logic              last_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lpff_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (action_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  lpff_datapath #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .frame_length_i (frame_length_i),
    .write_byte_i   (write_byte_i),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .length_out_o   (length_out_o),
    .read_byte_o    (read_byte_o),
    .last_o         (last_o)
  );

endmodule
